FILE: sv/gwms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwms_pkg
// Shared widths, register indexes and reset values of the gated window mean and deviation.
// ----------------------------------------------------------------------------
package gwms_pkg;

	localparam int DATA_W = 24;
	localparam int RAW_W = 20;
	localparam int MULT_W = 4;
	localparam int DEV_W = 30;
	localparam int CFG_IDX_W = 8;

	// The window size is a power of two; the mean and the root rely on shifts by it.
	localparam int WINDOW_SIZE = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MIN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MAX = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MULTIPLIER = 8'd3;

	localparam logic [DATA_W-1:0] RST_LIMIT_MIN = 24'd1600;
	localparam logic [DATA_W-1:0] RST_LIMIT_MAX = 24'd80000;
	localparam logic [MULT_W-1:0] RST_MULTIPLIER = 4'd1;

endpackage
`default_nettype wire

FILE: sv/gated_window_mean_stdev.sv
`timescale 1ns / 1ps
`default_nettype none
// From an accepted item to its result: a walk that reads every entry of the window, three setup
// steps (product, subtract, scale), then one root step per result bit.
// The first stored reading first writes its value to every entry of the window.
// Throughput: one item at a time; the next item is taken in the cycle its result appears.
// Items that leave the window unfilled or find the sensor disabled go straight from idle to done.
// Reset clears state and loads the reset configuration; the window memory is undefined until filled.
// ----------------------------------------------------------------------------
// gated_window_mean_stdev
// Gated moving window mean and sample standard deviation of distance readings.
// ----------------------------------------------------------------------------
module gated_window_mean_stdev
	import gwms_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DATA_W-1:0]    cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [RAW_W-1:0]     raw_value,
	input  wire logic                 value_present,
	input  wire logic                 store_sample,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      accepted,
	output logic [DATA_W-1:0]         last_value,
	output logic                      last_valid,
	output logic [DATA_W-1:0]         window_mean,
	output logic                      mean_valid,
	output logic [DEV_W-1:0]          deviation_x100
);

	localparam int CLOG = $clog2(WINDOW_SIZE);
	localparam int CNT_W = CLOG + 1;
	localparam int SUM_W = DATA_W + CLOG;
	localparam int SQ_W = 2 * DATA_W + CLOG;
	localparam int S_W = 2 * DATA_W + 2 * CLOG;
	localparam int T_W = S_W + 14;
	localparam int CAND_W = T_W + 2;
	localparam int RS_W = 2 * DEV_W;
	localparam int STP_W = $clog2(DEV_W);

	typedef enum logic [3:0] {
		ST_IDLE, ST_FILL, ST_WALK, ST_PROD, ST_SUB, ST_TMUL, ST_ROOT, ST_DONE
	} state_t;

	state_t state_q;

	logic              en_q;
	logic [DATA_W-1:0] lmin_q, lmax_q;
	logic [MULT_W-1:0] mult_q;

	logic [DATA_W-1:0] mem_q [WINDOW_SIZE];
	logic [DATA_W-1:0] mem_rd_q;
	logic              mem_we;
	logic [CLOG-1:0]   mem_wa, mem_ra;
	logic [DATA_W-1:0] mem_wd;

	logic [CLOG-1:0]   slot_q;
	logic              empty_q;
	logic [DATA_W-1:0] latest_q;
	logic              good_q;
	logic              acc_q, mean_ok_q;

	logic [CNT_W-1:0]  cnt_q;
	logic              v_s1, v_s2;
	logic [DATA_W-1:0] val_s2;
	logic [2*DATA_W-1:0] sq_s2;
	logic [SUM_W-1:0]  sum_q;
	logic [SQ_W-1:0]   sumsq_q;
	logic [S_W-1:0]    nsq_q, sum2_q, s_q;
	logic [DATA_W-1:0] mean_q;

	logic [T_W-1:0]    t_q, p_q;
	logic [RS_W-1:0]   rs_q, pw_q, rt_term;
	logic [CAND_W-1:0] rt_cand;
	logic              rt_ge;
	logic [STP_W-1:0]  stp_q;

	logic [DATA_W-1:0] scaled;
	logic              good_in;
	logic              take;
	logic              out_free;
	logic              last_ok;

	assign scaled = DATA_W'(raw_value) * DATA_W'(mult_q);
	assign good_in = value_present && (scaled >= lmin_q) && (scaled <= lmax_q);
	assign in_stall = (state_q != ST_IDLE);
	assign take = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign last_ok = en_q && !empty_q && good_q;

	// One root bit per step: the candidate is (r + 2^b)^2 * n * (n - 1), built from r^2 * n * (n - 1).
	assign rt_term = rs_q | pw_q;
	assign rt_cand = CAND_W'(p_q) + (CAND_W'(rt_term) << (2 * CLOG)) -
		(CAND_W'(rt_term) << CLOG);
	assign rt_ge = rt_cand <= CAND_W'(t_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot_q;
		mem_wd = scaled;
		if (state_q == ST_FILL) begin
			mem_we = (cnt_q < CNT_W'(WINDOW_SIZE));
			mem_wa = cnt_q[CLOG-1:0];
			mem_wd = latest_q;
		end else if (take && en_q && good_in && store_sample && !empty_q) begin
			mem_we = 1'b1;
		end
	end

	assign mem_ra = cnt_q[CLOG-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem_q[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			lmin_q <= RST_LIMIT_MIN;
			lmax_q <= RST_LIMIT_MAX;
			mult_q <= RST_MULTIPLIER;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SENSOR_ENABLED: en_q <= cfg_data[0];
				REG_LIMIT_MIN: lmin_q <= cfg_data;
				REG_LIMIT_MAX: lmax_q <= cfg_data;
				REG_MULTIPLIER: mult_q <= cfg_data[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			slot_q <= '0;
			empty_q <= 1'b1;
			latest_q <= '0;
			good_q <= 1'b0;
			acc_q <= 1'b0;
			mean_ok_q <= 1'b0;
			cnt_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			val_s2 <= '0;
			sq_s2 <= '0;
			sum_q <= '0;
			sumsq_q <= '0;
			nsq_q <= '0;
			sum2_q <= '0;
			s_q <= '0;
			mean_q <= '0;
			t_q <= '0;
			p_q <= '0;
			rs_q <= '0;
			pw_q <= '0;
			stp_q <= '0;
			out_valid <= 1'b0;
			accepted <= 1'b0;
			last_value <= '0;
			last_valid <= 1'b0;
			window_mean <= '0;
			mean_valid <= 1'b0;
			deviation_x100 <= '0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						cnt_q <= '0;
						sum_q <= '0;
						sumsq_q <= '0;
						v_s1 <= 1'b0;
						v_s2 <= 1'b0;
						if (!en_q) begin
							good_q <= 1'b0;
							acc_q <= 1'b1;
							mean_ok_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (!good_in) begin
							good_q <= 1'b0;
							acc_q <= 1'b0;
							mean_ok_q <= !empty_q;
							state_q <= empty_q ? ST_DONE : ST_WALK;
						end else begin
							latest_q <= scaled;
							good_q <= 1'b1;
							acc_q <= store_sample;
							mean_ok_q <= !empty_q || store_sample;
							if (store_sample && empty_q) begin
								empty_q <= 1'b0;
								state_q <= ST_FILL;
							end else if (store_sample) begin
								slot_q <= (slot_q == CLOG'(WINDOW_SIZE - 1)) ?
									'0 : slot_q + 1'b1;
								state_q <= ST_WALK;
							end else begin
								state_q <= empty_q ? ST_DONE : ST_WALK;
							end
						end
					end
				end
				ST_FILL: begin
					if (cnt_q == CNT_W'(WINDOW_SIZE)) begin
						cnt_q <= '0;
						state_q <= ST_WALK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WALK: begin
					v_s1 <= (cnt_q < CNT_W'(WINDOW_SIZE));
					if (cnt_q < CNT_W'(WINDOW_SIZE)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					v_s2 <= v_s1;
					val_s2 <= mem_rd_q;
					sq_s2 <= mem_rd_q * mem_rd_q;
					if (v_s2) begin
						sum_q <= sum_q + SUM_W'(val_s2);
						sumsq_q <= sumsq_q + SQ_W'(sq_s2);
					end
					if (cnt_q == CNT_W'(WINDOW_SIZE) && !v_s1 && !v_s2) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					nsq_q <= S_W'(sumsq_q) * S_W'(WINDOW_SIZE);
					sum2_q <= S_W'(sum_q) * S_W'(sum_q);
					mean_q <= sum_q[SUM_W-1:CLOG];
					state_q <= ST_SUB;
				end
				ST_SUB: begin
					s_q <= (nsq_q >= sum2_q) ? nsq_q - sum2_q : '0;
					state_q <= ST_TMUL;
				end
				ST_TMUL: begin
					t_q <= T_W'(s_q) * T_W'(10000);
					p_q <= '0;
					rs_q <= '0;
					pw_q <= RS_W'(1) << (RS_W - 2);
					stp_q <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (rt_ge) begin
						p_q <= T_W'(rt_cand);
					end
					rs_q <= (rs_q >> 1) | (rt_ge ? pw_q : '0);
					pw_q <= pw_q >> 2;
					stp_q <= stp_q + 1'b1;
					if (stp_q == STP_W'(DEV_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						accepted <= acc_q;
						last_valid <= last_ok;
						last_value <= last_ok ? latest_q : '0;
						mean_valid <= mean_ok_q;
						window_mean <= mean_ok_q ? mean_q : '0;
						deviation_x100 <= mean_ok_q ? rs_q[DEV_W-1:0] : '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: sv/gwms_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gwms_checker
// Port level checks of result consistency, bound to the top level.
// ----------------------------------------------------------------------------
module gwms_checker
	import gwms_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [DATA_W-1:0] last_value,
	input wire logic              last_valid,
	input wire logic [DATA_W-1:0] window_mean,
	input wire logic              mean_valid,
	input wire logic [DEV_W-1:0]  deviation_x100
);

	a_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mean_valid |-> window_mean == '0 && deviation_x100 == '0)
		else $error("window statistics nonzero while mean is invalid");

	a_last_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_valid |-> last_value == '0)
		else $error("last value nonzero while invalid");

	a_last_needs_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_valid |-> mean_valid)
		else $error("last value valid without a filled window");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(window_mean)
			&& $stable(deviation_x100))
		else $error("stalled result changed");

endmodule

bind gated_window_mean_stdev gwms_checker u_gwms_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.last_value(last_value),
	.last_valid(last_valid),
	.window_mean(window_mean),
	.mean_valid(mean_valid),
	.deviation_x100(deviation_x100)
);
`default_nettype wire

FILE: tb/gated_window_mean_stdev_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_window_mean_stdev_test
// Drives readings through the gated window block under changing limits,
// multipliers, sensor enables, idle and stall phases, and checks every result against a predictor.
// ----------------------------------------------------------------------------
module gated_window_mean_stdev_test;
	import gwms_pkg::*;

	localparam int WIN = WINDOW_SIZE;

	typedef struct packed {
		logic               acc;
		logic [DATA_W-1:0]  last;
		logic               last_ok;
		logic [DATA_W-1:0]  mean;
		logic               mean_ok;
		logic [DEV_W-1:0]   dev;
	} result_t;

	typedef struct {
		logic [RAW_W-1:0] raw;
		logic             present;
		logic             store;
		logic             known;
		result_t          res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic [RAW_W-1:0] raw_value = '0;
	logic value_present = 0;
	logic store_sample = 0;
	logic out_valid;
	logic out_stall = 0;
	logic accepted;
	logic [DATA_W-1:0] last_value;
	logic last_valid;
	logic [DATA_W-1:0] window_mean;
	logic mean_valid;
	logic [DEV_W-1:0] deviation_x100;

	gated_window_mean_stdev dut (.*);

	logic               p_enabled;
	logic [DATA_W-1:0]  p_min, p_max;
	logic [MULT_W-1:0]  p_mult;
	logic [DATA_W-1:0]  p_window [WIN];
	int unsigned        p_slot;
	logic               p_empty;
	logic [DATA_W-1:0]  p_latest;
	logic               p_good;

	result_t expected_results[$];
	int errors = 0;
	int send_idle = 0;
	int recv_stall = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL gated_window_mean_stdev");
		$finish;
	end

	function automatic logic [DEV_W-1:0] deviation_root(longint unsigned s, int unsigned d);
		logic [127:0] target, prod;
		logic [31:0] r, c;
		target = 128'(s) * 128'd10000;
		r = 0;
		for (int b = 29; b >= 0; b--) begin
			c = r | (32'd1 << b);
			prod = 128'(c) * 128'(c) * 128'(d);
			if (prod <= target)
				r = c;
		end
		return r[DEV_W-1:0];
	endfunction

	function automatic result_t predict_reading(logic [RAW_W-1:0] raw, logic present,
		logic store);
		result_t r;
		logic [DATA_W-1:0] scaled;
		longint unsigned sum, sumsq, s;
		r = '0;
		if (!p_enabled) begin
			p_good = 0;
			r.acc = 1;
		end else begin
			scaled = DATA_W'(raw) * DATA_W'(p_mult);
			if (!present || scaled < p_min || scaled > p_max) begin
				p_good = 0;
			end else begin
				p_latest = scaled;
				p_good = 1;
				if (store) begin
					r.acc = 1;
					if (p_empty) begin
						p_empty = 0;
						for (int i = 0; i < WIN; i++) p_window[i] = scaled;
					end else begin
						p_window[p_slot] = scaled;
						p_slot = (p_slot + 1) % WIN;
					end
				end
			end
		end
		r.last_ok = p_enabled && !p_empty && p_good;
		r.mean_ok = p_enabled && !p_empty;
		if (r.last_ok) r.last = p_latest;
		if (r.mean_ok) begin
			sum = 0;
			sumsq = 0;
			for (int i = 0; i < WIN; i++) begin
				sum += p_window[i];
				sumsq += longint'(p_window[i]) * p_window[i];
			end
			r.mean = DATA_W'(sum / WIN);
			s = WIN * sumsq;
			s = (s >= sum * sum) ? s - sum * sum : 0;
			r.dev = deviation_root(s, WIN * (WIN - 1));
		end
		return r;
	endfunction

	always @(posedge clk) begin
		result_t got, exp_r;
		if (out_valid && !out_stall) begin
			got = '{accepted, last_value, last_valid, window_mean, mean_valid,
				deviation_x100};
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, got);
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r) begin
					errors++;
					$display("%0t: expected %p actual %p", $time, exp_r, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_SENSOR_ENABLED: p_enabled = val[0];
			REG_LIMIT_MIN: p_min = val;
			REG_LIMIT_MAX: p_max = val;
			REG_MULTIPLIER: p_mult = val[MULT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_reading(logic [RAW_W-1:0] raw, logic present, logic store,
		logic known, result_t res);
		result_t pred;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		in_valid <= 1;
		raw_value <= raw;
		value_present <= present;
		store_sample <= store;
		pred = predict_reading(raw, present, store);
		if (known && pred !== res) begin
			errors++;
			$display("%0t: table expected %p predictor %p", $time, res, pred);
		end
		expected_results.push_back(pred);
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic drain();
		while (expected_results.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic random_readings(int n);
		logic [RAW_W-1:0] raw;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: raw = RAW_W'($urandom);
				1: raw = '1;
				default: raw = RAW_W'($urandom_range(p_max / (p_mult == 0 ? 1 : p_mult)
					+ 20, p_min / (p_mult == 0 ? 1 : p_mult)));
			endcase
			send_reading(raw, $urandom_range(9) != 0, $urandom_range(3) != 0, 0, '0);
		end
	endtask

	row_t table_rows[] = '{
		'{20'd2000, 1, 1, 1, '{1, 24'd2000, 1, 24'd2000, 1, 0}},
		'{20'd100, 1, 1, 1, '{0, 0, 0, 24'd2000, 1, 0}},
		'{20'd1600, 1, 1, 0, '0},
		'{20'd80000, 1, 1, 0, '0},
		'{20'd80001, 1, 1, 0, '0},
		'{20'd5000, 1, 0, 0, '0},
		'{20'd5000, 0, 1, 0, '0},
		'{20'hFFFFF, 1, 1, 0, '0},
		'{20'd0, 1, 1, 0, '0},
		'{20'd40000, 1, 1, 0, '0},
		'{20'd1599, 1, 1, 0, '0}
	};

	initial begin
		int phase_idle [4] = '{0, 61, 0, 27};
		int phase_stall [4] = '{0, 0, 61, 27};
		p_enabled = 1;
		p_min = RST_LIMIT_MIN;
		p_max = RST_LIMIT_MAX;
		p_mult = RST_MULTIPLIER;
		p_slot = 0;
		p_empty = 1;
		p_latest = 0;
		p_good = 0;
		for (int i = 0; i < WIN; i++) p_window[i] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		foreach (table_rows[i])
			send_reading(table_rows[i].raw, table_rows[i].present, table_rows[i].store,
				table_rows[i].known, table_rows[i].res);
		drain();
		write_reg(REG_SENSOR_ENABLED, 0);
		send_reading(20'd3000, 1, 1, 1, '{1, 0, 0, 0, 0, 0});
		drain();
		write_reg(REG_SENSOR_ENABLED, 1);
		write_reg(REG_MULTIPLIER, 0);
		send_reading(20'd3000, 1, 1, 0, '0);
		drain();
		write_reg(REG_MULTIPLIER, 15);
		write_reg(REG_LIMIT_MAX, '1);
		write_reg(REG_LIMIT_MIN, 0);
		send_reading(20'hFFFFF, 1, 1, 0, '0);
		send_reading(20'd0, 1, 1, 0, '0);
		drain();
		write_reg(REG_LIMIT_MIN, 24'd9000);
		write_reg(REG_LIMIT_MAX, 24'd100);
		send_reading(20'd5000, 1, 1, 0, '0);
		drain();
		for (int ph = 0; ph < 8; ph++) begin
			send_idle = phase_idle[ph % 4];
			recv_stall = phase_stall[ph % 4];
			write_reg(REG_MULTIPLIER, MULT_W'($urandom_range(15, 1)));
			write_reg(REG_LIMIT_MIN, DATA_W'($urandom_range(20000)));
			write_reg(REG_LIMIT_MAX, DATA_W'($urandom_range(16777215, 20001)));
			write_reg(REG_SENSOR_ENABLED, DATA_W'(ph != 5));
			random_readings(78);
			drain();
		end
		if (errors == 0)
			$display("PASS gated_window_mean_stdev");
		else
			$display("FAIL gated_window_mean_stdev");
		$finish;
	end

endmodule

FILE: filelist.f
sv/gwms_pkg.sv
sv/gated_window_mean_stdev.sv
sv/gwms_checker.sv
tb/gated_window_mean_stdev_test.sv
